// File: rtl/core/gmbp_pkg.sv
package gmbp_pkg;

    typedef enum logic [1:0] {
        KIND_MARKER = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_COUNT  = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    localparam logic [63:0] ONE_PATTERN = 64'h3FF0_0000_0000_0000;
    localparam logic        CFG_GROUP_SIZE = 1'b0;
    localparam logic        CFG_MISSING    = 1'b1;

    // datapath commands from the controller
    typedef struct packed {
        logic       take;        // store sample, update fill and tally
        logic       rd_start;    // issue RAM read at index 0
        logic       rd_next;     // advance RAM read index
        logic       emit;        // load output register
        kind_t      kind;
        logic [1:0] src;         // payload source
        logic       last;
        logic       close;       // clear fill/tally, bump count if present
        logic       clear_msg;   // clear count
    } gmbp_cmd_t;

    localparam logic [1:0] SRC_MARKER = 2'd0;
    localparam logic [1:0] SRC_RAM    = 2'd1;
    localparam logic [1:0] SRC_COUNT  = 2'd2;
    localparam logic [1:0] SRC_ZERO   = 2'd3;

    typedef struct packed {
        logic group_done;     // fill reaches size after this take
        logic group_missing;  // all held values missing
        logic partial;        // values remain in open group
        logic replay_last;    // read index is last held value
        logic out_free;       // output register may be loaded
    } gmbp_stat_t;

    // floating-point equality: NaN equals nothing, +0 equals -0
    function automatic logic fp_eq(input logic [63:0] a, input logic [63:0] b);
        logic a_nan;
        logic b_nan;
        a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        fp_eq = !a_nan && !b_nan &&
                ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
    endfunction

endpackage

// File: rtl/core/gmbp_ram.sv
module gmbp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/gmbp_datapath.sv
module gmbp_datapath
    import gmbp_pkg::*;
#(
    parameter int MAX_GROUP  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic [63:0] sample_bits,
    input  gmbp_cmd_t   cmd,
    output gmbp_stat_t  stat,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  item_kind,
    output logic [63:0] payload,
    output logic        last_of_run
);
    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int FW = $clog2(MAX_GROUP + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [4:0]            size_reg;
    logic [63:0]           missing_reg;
    logic [FW-1:0]         fill_reg, tally_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [FW-1:0]         rd_reg;
    logic [FW-1:0]         eff_size, fill_next, tally_next;
    logic                  sample_miss, full;
    logic [63:0]           rdata, marker, src_data;
    logic [AW-1:0]         raddr;
    logic                  ovalid_reg;
    logic [1:0]            okind_reg;
    logic [63:0]           opay_reg;
    logic                  olast_reg;

    always_comb
    begin
        if (size_reg == 5'd0)
            eff_size = FW'(1);
        else if (32'(size_reg) > MAX_GROUP)
            eff_size = FW'(MAX_GROUP);
        else
            eff_size = FW'(size_reg);
    end

    assign full        = (32'(fill_reg) >= MAX_GROUP);
    assign sample_miss = fp_eq(sample_bits, missing_reg);
    assign fill_next   = full ? fill_reg : fill_reg + FW'(1);
    assign tally_next  = (full || !sample_miss) ? tally_reg : tally_reg + FW'(1);

    // rd_reg points one past the value on the read data; it reaches fill on the last one
    assign stat.group_done    = (fill_next >= eff_size);
    assign stat.group_missing = (tally_reg == fill_reg);
    assign stat.partial       = (fill_reg != '0);
    assign stat.replay_last   = (rd_reg >= fill_reg);
    assign stat.out_free      = !ovalid_reg || out_ready;

    // hold the current address while the output stalls so read data stays put
    assign raddr = cmd.rd_start ? AW'(0) :
                   cmd.rd_next  ? AW'(rd_reg) : AW'(rd_reg - FW'(1));

    gmbp_ram #(.WIDTH(64), .DEPTH(MAX_GROUP)) u_store (
        .clk   (clk),
        .we    (cmd.take && !full),
        .waddr (AW'(fill_reg)),
        .wdata (sample_bits),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign marker = fp_eq(missing_reg, 64'd0) ? ONE_PATTERN : 64'd0;

    always_comb
    begin
        unique case (cmd.src)
            SRC_MARKER: src_data = stat.group_missing ? missing_reg : marker;
            SRC_RAM:    src_data = rdata;
            SRC_COUNT:  src_data = 64'(count_reg);
            default:    src_data = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= 5'd1;
            missing_reg <= 64'd0;
            fill_reg    <= '0;
            tally_reg   <= '0;
            count_reg   <= '0;
            rd_reg      <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_GROUP_SIZE)
                    size_reg <= cfg_data[4:0];
                else
                    missing_reg <= cfg_data;
            end
            if (cmd.take)
            begin
                fill_reg  <= fill_next;
                tally_reg <= tally_next;
            end
            if (cmd.rd_start)
                rd_reg <= FW'(1);
            else if (cmd.rd_next)
                rd_reg <= rd_reg + FW'(1);
            if (cmd.close)
            begin
                fill_reg  <= '0;
                tally_reg <= '0;
                if (!stat.group_missing && count_reg != CNT_MAX)
                    count_reg <= count_reg + COUNT_BITS'(1);
            end
            if (cmd.clear_msg)
            begin
                fill_reg  <= '0;
                tally_reg <= '0;
                count_reg <= '0;
            end
            if (cmd.emit)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            okind_reg <= cmd.kind;
            opay_reg  <= src_data;
            olast_reg <= cmd.last;
        end
    end

    assign out_valid   = ovalid_reg;
    assign item_kind   = okind_reg;
    assign payload     = opay_reg;
    assign last_of_run = olast_reg;

    a_tally_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        tally_reg <= fill_reg) else $error("tally above fill");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= MAX_GROUP) else $error("fill above max");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free) else $error("emit over pending beat");
endmodule

// File: rtl/core/gmbp_ctrl.sv
module gmbp_ctrl
    import gmbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       end_of_message,
    input  gmbp_stat_t stat,
    output gmbp_cmd_t  cmd,
    output logic       busy
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MARK,
        S_REPLAY,
        S_TAIL
    } state_t;

    state_t state_reg, state_next;
    logic   eom_reg, eom_next;

    assign in_ready = (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.kind   = KIND_MARKER;
        cmd.src    = SRC_MARKER;
        state_next = state_reg;
        eom_next   = eom_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    eom_next = end_of_message;
                    if (stat.group_done)
                        state_next = S_MARK;
                    else if (end_of_message)
                        state_next = S_TAIL;
                end
            end
            S_CHECK:
                state_next = S_IDLE;
            S_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_MARKER;
                    cmd.src  = SRC_MARKER;
                    if (stat.group_missing)
                    begin
                        cmd.close = 1'b1;
                        cmd.last  = !eom_reg;
                        state_next = eom_reg ? S_TAIL : S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = S_REPLAY;
                    end
                end
            end
            S_REPLAY:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_VALUE;
                    cmd.src     = SRC_RAM;
                    cmd.rd_next = 1'b1;
                    if (stat.replay_last)
                    begin
                        cmd.close  = 1'b1;
                        cmd.last   = !eom_reg;
                        state_next = eom_reg ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = stat.partial ? KIND_ERROR : KIND_COUNT;
                    cmd.src       = stat.partial ? SRC_ZERO : SRC_COUNT;
                    cmd.last      = 1'b1;
                    cmd.clear_msg = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            eom_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            eom_reg   <= eom_next;
        end
    end

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> state_reg == S_IDLE) else $error("take outside idle");
    a_close_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |-> cmd.emit) else $error("close without beat");
    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_msg |-> cmd.last) else $error("message end not last");
endmodule

// File: rtl/core/group_missing_bitmap_packer_unit.sv
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid / in_ready   | sample_bits[63:0], end_of_message
// out     | out | out_valid / out_ready | item_kind[1:0], payload[63:0], last_of_run
// cfg     | in  | cfg_valid / cfg_ready | cfg_index (0 group_size, 1 missing), cfg_data
//
// An input beat that does not close a group is taken in the idle state; a closing
// beat then emits a marker and, for a present group, replays each held value,
// followed by the count/error beat at message end. While out_ready stays high, one
// result per cycle is set by the store's single read port and the output register.
// Reset clears control and counters, sets group size 1 and missing value 0; the group store has no reset.
// A stalled out_ready holds the controller in its current emit state.
module group_missing_bitmap_packer_unit
    import gmbp_pkg::*;
#(
    parameter int MAX_GROUP  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] sample_bits,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  item_kind,
    output logic [63:0] payload,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    gmbp_cmd_t  cmd;
    gmbp_stat_t stat;
    logic       busy;

    // config beats land only between input beats, never mid-group-emit
    assign cfg_ready = !busy;

    gmbp_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .end_of_message (end_of_message),
        .stat           (stat),
        .cmd            (cmd),
        .busy           (busy)
    );

    gmbp_datapath #(.MAX_GROUP(MAX_GROUP), .COUNT_BITS(COUNT_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_bits (sample_bits),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_kind   (item_kind),
        .payload     (payload),
        .last_of_run (last_of_run)
    );

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !busy) else $error("ready while busy");
    a_accept_known: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (busy || !$past(end_of_message)))
        else $error("message end dropped");
    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("beat lost");
endmodule
